// ===== design/cdte_pkg.sv =====
// Package with the calendar constants and small helper functions of the date converter.
`timescale 1ns / 1ps

package cdte_pkg;

    localparam logic [11:0] EPOCH_YEAR   = 12'd1970;
    localparam logic [11:0] LAST_YEAR    = 12'd2099;
    localparam logic [3:0]  FIRST_MONTH  = 4'd1;
    localparam logic [3:0]  LAST_MONTH   = 4'd12;
    localparam logic [2:0]  EPOCH_WDAY   = 3'd4;
    localparam logic [2:0]  DAYS_IN_WEEK = 3'd7;
    localparam logic [4:0]  LAST_RULE    = 5'd5;
    localparam logic [8:0]  DAYS_IN_YEAR = 9'd365;
    localparam logic [16:0] SECS_PER_HOUR = 17'd3600;
    localparam logic [16:0] SECS_PER_MIN  = 17'd60;
    localparam logic [31:0] SECS_PER_DAY  = 32'd86400;

    localparam logic REQ_ABSOLUTE = 1'b0;
    localparam logic REQ_RULE     = 1'b1;

    // Days in all months before the given one, with February 29 counted in a leap year.
    function automatic logic [8:0] month_cum_days(input logic [3:0] month, input logic leap);
        logic [8:0] cum;
        begin
            case (month)
                4'd1:    cum = 9'd0;
                4'd2:    cum = 9'd31;
                4'd3:    cum = 9'd59;
                4'd4:    cum = 9'd90;
                4'd5:    cum = 9'd120;
                4'd6:    cum = 9'd151;
                4'd7:    cum = 9'd181;
                4'd8:    cum = 9'd212;
                4'd9:    cum = 9'd243;
                4'd10:   cum = 9'd273;
                4'd11:   cum = 9'd304;
                4'd12:   cum = 9'd334;
                default: cum = 9'd0;
            endcase
            // February 29 falls before every month after February in a leap year.
            if (leap && month > 4'd2) begin
                cum = cum + 9'd1;
            end
            return cum;
        end
    endfunction

    function automatic logic [4:0] month_len(input logic [3:0] month, input logic leap);
        logic [4:0] len;
        begin
            case (month)
                4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
                4'd4, 4'd6, 4'd9, 4'd11:                   len = 5'd30;
                4'd2:    len = leap ? 5'd29 : 5'd28;
                default: len = 5'd0;
            endcase
            return len;
        end
    endfunction

    // Remainder by 7 by folding octal digits, since 8 is 1 modulo 7.
    function automatic logic [2:0] mod7(input logic [15:0] x);
        logic [5:0] s1;
        logic [3:0] s2;
        begin
            s1 = 6'(x[2:0]) + 6'(x[5:3]) + 6'(x[8:6]) + 6'(x[11:9]) + 6'(x[14:12])
               + 6'(x[15]);
            s2 = 4'(s1[2:0]) + 4'(s1[5:3]);
            if (s2 >= 4'(DAYS_IN_WEEK)) begin
                s2 = s2 - 4'(DAYS_IN_WEEK);
            end
            return s2[2:0];
        end
    endfunction

endpackage

// ===== design/calendar_date_to_epoch_seconds.sv =====
// Top level of the pipelined converter from a UTC calendar date to epoch seconds.
`timescale 1ns / 1ps

// Usage
// A transaction enters when start is high at a rising clock edge and busy is low.
// busy is held low: the pipeline takes a new transaction in every cycle, so
// the sustained rate is one transaction per clock.
// Each transaction gives exactly one result. It appears on o_epoch_seconds and
// o_bad_input for exactly one cycle, marked by o_done, once it has passed the
// five stage registers and then the output register.
// Results come out in the order the transactions went in.
// The receiver cannot stall the block, so there is no back pressure and no
// buffering beyond the pipeline registers.
// A year outside 1970 to 2099, a month outside 1 to 12, or a day of zero
// sets o_bad_input and forces o_epoch_seconds to zero.
// Mode 0 of i_req_type takes i_day as the day of the month; mode 1 takes it as
// the nth weekday (1 to 4) or the last one (5 or more) of the month.
// A synchronous active-low reset empties the pipeline: transactions in flight
// are dropped and o_done stays low until new transactions reach the output.
// Stage work: calendar lookups and constant products, day count sum, weekday
// of the first of the month, day offset, day to seconds product, final sum.
module calendar_date_to_epoch_seconds (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        i_req_type,
    input  logic [11:0] i_year,
    input  logic [3:0]  i_month,
    input  logic [4:0]  i_day,
    input  logic [2:0]  i_week_day,
    input  logic [4:0]  i_hour,
    input  logic [5:0]  i_minute,
    input  logic [5:0]  i_second,
    output logic        o_done,
    output logic [31:0] o_epoch_seconds,
    output logic        o_bad_input
);
    import cdte_pkg::*;

    localparam int LATENCY = 6;

    // Stage 1: input checks, year and month day counts, time of day.
    logic        r_s1_vld;
    logic        r_s1_bad;
    logic        r_s1_mode;
    logic [4:0]  r_s1_day;
    logic [2:0]  r_s1_wday;
    logic [4:0]  r_s1_mlen;
    logic [15:0] r_s1_year_days;
    logic [8:0]  r_s1_cum;
    logic [16:0] r_s1_tod;

    logic        n_s1_bad;
    logic [7:0]  n_s1_yoff;
    logic        n_s1_leap;
    logic [15:0] n_s1_year_days;
    logic [16:0] n_s1_tod;

    always_comb begin
        n_s1_bad = (i_year < EPOCH_YEAR) || (i_year > LAST_YEAR) ||
                   (i_month < FIRST_MONTH) || (i_month > LAST_MONTH) || (i_day == 5'd0);
        n_s1_yoff = 8'(i_year - EPOCH_YEAR);
        // Within 1970..2099 every fourth year is leap, 2000 included.
        n_s1_leap = (i_year[1:0] == 2'd0);
        // Leap days in the years 1970 up to the one before this: (yoff + 1) / 4.
        n_s1_year_days = 16'({8'd0, n_s1_yoff} * 16'(DAYS_IN_YEAR))
                       + 16'((9'(n_s1_yoff) + 9'd1) >> 2);
        n_s1_tod = 17'(i_hour) * SECS_PER_HOUR + 17'(i_minute) * SECS_PER_MIN
                 + 17'(i_second);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else begin
            r_s1_vld <= start && !busy;
        end
        r_s1_bad       <= n_s1_bad;
        r_s1_mode      <= i_req_type;
        r_s1_day       <= i_day;
        r_s1_wday      <= (i_week_day == DAYS_IN_WEEK) ? 3'd0 : i_week_day;
        r_s1_mlen      <= month_len(i_month, n_s1_leap);
        r_s1_year_days <= n_s1_year_days;
        r_s1_cum       <= month_cum_days(i_month, n_s1_leap);
        r_s1_tod       <= n_s1_tod;
    end

    // Stage 2: days from the epoch to the first of the month.
    logic        r_s2_vld;
    logic        r_s2_bad;
    logic        r_s2_mode;
    logic [4:0]  r_s2_day;
    logic [2:0]  r_s2_wday;
    logic [4:0]  r_s2_mlen;
    logic [15:0] r_s2_days;
    logic [16:0] r_s2_tod;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_vld <= 1'b0;
        end else begin
            r_s2_vld <= r_s1_vld;
        end
        r_s2_bad  <= r_s1_bad;
        r_s2_mode <= r_s1_mode;
        r_s2_day  <= r_s1_day;
        r_s2_wday <= r_s1_wday;
        r_s2_mlen <= r_s1_mlen;
        r_s2_days <= r_s1_year_days + 16'(r_s1_cum);
        r_s2_tod  <= r_s1_tod;
    end

    // Stage 3: days from the first of the month to the first wanted weekday.
    logic        r_s3_vld;
    logic        r_s3_bad;
    logic        r_s3_mode;
    logic [4:0]  r_s3_day;
    logic [2:0]  r_s3_hit;
    logic [4:0]  r_s3_mlen;
    logic [15:0] r_s3_days;
    logic [16:0] r_s3_tod;

    logic [2:0]  n_s3_fdow;
    logic [3:0]  n_s3_hit;

    always_comb begin
        n_s3_fdow = mod7(r_s2_days + 16'(EPOCH_WDAY));
        n_s3_hit  = 4'(r_s2_wday) + 4'(DAYS_IN_WEEK) - 4'(n_s3_fdow);
        if (n_s3_hit >= 4'(DAYS_IN_WEEK)) begin
            n_s3_hit = n_s3_hit - 4'(DAYS_IN_WEEK);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_vld <= 1'b0;
        end else begin
            r_s3_vld <= r_s2_vld;
        end
        r_s3_bad  <= r_s2_bad;
        r_s3_mode <= r_s2_mode;
        r_s3_day  <= r_s2_day;
        r_s3_hit  <= n_s3_hit[2:0];
        r_s3_mlen <= r_s2_mlen;
        r_s3_days <= r_s2_days;
        r_s3_tod  <= r_s2_tod;
    end

    // Stage 4: total day count including the day within the month.
    logic        r_s4_vld;
    logic        r_s4_bad;
    logic [15:0] r_s4_days;
    logic [16:0] r_s4_tod;

    logic [5:0]  n_s4_offset;
    logic [4:0]  n_s4_rest;

    always_comb begin
        n_s4_rest = r_s3_mlen - 5'd1 - 5'(r_s3_hit);
        if (r_s3_mode == REQ_ABSOLUTE) begin
            n_s4_offset = 6'(r_s3_day - 5'd1);
        end else if (r_s3_day < LAST_RULE) begin
            n_s4_offset = 6'(r_s3_hit) + 6'(r_s3_day - 5'd1) * 6'(DAYS_IN_WEEK);
        end else begin
            // The last occurrence is four or three weeks after the first one.
            n_s4_offset = 6'(r_s3_hit) + ((n_s4_rest >= 5'd28) ? 6'd28 : 6'd21);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s4_vld <= 1'b0;
        end else begin
            r_s4_vld <= r_s3_vld;
        end
        r_s4_bad  <= r_s3_bad;
        r_s4_days <= r_s3_days + 16'(n_s4_offset);
        r_s4_tod  <= r_s3_tod;
    end

    // Stage 5: days to seconds.
    logic        r_s5_vld;
    logic        r_s5_bad;
    logic [31:0] r_s5_prod;
    logic [16:0] r_s5_tod;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s5_vld <= 1'b0;
        end else begin
            r_s5_vld <= r_s4_vld;
        end
        r_s5_bad  <= r_s4_bad;
        r_s5_prod <= {16'd0, r_s4_days} * SECS_PER_DAY;
        r_s5_tod  <= r_s4_tod;
    end

    // Output register: add the time of day and clear the result on bad input.
    logic        r_done;
    logic [31:0] r_epoch;
    logic        r_bad;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= r_s5_vld;
        end
        r_epoch <= r_s5_bad ? 32'd0 : (r_s5_prod + 32'(r_s5_tod));
        r_bad   <= r_s5_bad;
    end

    // Every stage advances each cycle, so the block never refuses a transaction.
    assign busy            = 1'b0;
    assign o_done          = r_done;
    assign o_epoch_seconds = r_epoch;
    assign o_bad_input     = r_bad;

`ifndef SYNTHESIS
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##LATENCY o_done)
        else $error("accepted transaction did not complete after the pipeline latency");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(start && !busy, LATENCY))
        else $error("result strobe without a matching accepted transaction");

    a_bad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_bad_input) |-> (o_epoch_seconds == 32'd0))
        else $error("flagged result carries a nonzero value");

    a_early_year: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_year < EPOCH_YEAR)) |-> ##LATENCY o_bad_input)
        else $error("year before the epoch was not flagged");
`endif

endmodule

// ===== tb/sv/tb_calendar_date_to_epoch_seconds.sv =====
// Self-checking testbench for the calendar date to epoch seconds converter.
`timescale 1ns / 1ps

// One conversion request as it is driven onto the input ports.
typedef struct {
    logic        req_type;
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [2:0]  week_day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
} date_request_t;

// Keeps the expected conversions in order and compares each result strobe with the oldest one.
class epoch_scoreboard;
    typedef struct {
        logic [31:0] secs;
        logic        bad;
    } conversion_t;

    conversion_t pending_results[$];
    int unsigned accepted;
    int unsigned checked;
    int unsigned flagged;
    int unsigned failures;

    function new();
        accepted = 0;
        checked  = 0;
        flagged  = 0;
        failures = 0;
    endfunction

    static function int unsigned month_length(int unsigned m, bit leap);
        case (m)
            4, 6, 9, 11: return 30;
            2:           return leap ? 29 : 28;
            default:     return 31;
        endcase
    endfunction

    // Leap years counted from year 1 through y.
    static function int unsigned leap_years_through(int unsigned y);
        return y / 4 - y / 100 + y / 400;
    endfunction

    static function conversion_t convert_date(date_request_t r);
        conversion_t res;
        int unsigned y, m, d, wd, days, offset, first_dow, first_hit, mlen;
        bit          leap;
        longint unsigned total;
        y  = r.year;
        m  = r.month;
        d  = r.day;
        wd = r.week_day % 7;
        if (y < cdte_pkg::EPOCH_YEAR || y > cdte_pkg::LAST_YEAR || m < 1 || m > 12 || d == 0) begin
            res.secs = '0;
            res.bad  = 1'b1;
            return res;
        end
        leap = (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
        days = 365 * (y - cdte_pkg::EPOCH_YEAR)
             + leap_years_through(y - 1) - leap_years_through(cdte_pkg::EPOCH_YEAR - 1);
        for (int unsigned mm = 1; mm < m; mm++) begin
            days += month_length(mm, leap);
        end
        if (r.req_type == cdte_pkg::REQ_ABSOLUTE) begin
            offset = d - 1;
        end else begin
            mlen      = month_length(m, leap);
            first_dow = (days + cdte_pkg::EPOCH_WDAY) % 7;
            first_hit = (wd + 7 - first_dow) % 7;
            if (d < cdte_pkg::LAST_RULE) begin
                offset = first_hit + 7 * (d - 1);
            end else begin
                offset = first_hit + 7 * ((mlen - 1 - first_hit) / 7);
            end
        end
        total = longint'(days + offset) * 86400 + longint'(r.hour) * 3600
              + longint'(r.minute) * 60 + longint'(r.second);
        res.secs = total[31:0];
        res.bad  = 1'b0;
        return res;
    endfunction

    function void note_request(date_request_t r);
        conversion_t res;
        res = convert_date(r);
        accepted++;
        if (res.bad) begin
            flagged++;
        end
        pending_results.push_back(res);
    endfunction

    function void check_result(logic [31:0] secs, logic bad);
        conversion_t want;
        if (pending_results.size() == 0) begin
            $error("result strobe with no request outstanding: epoch_seconds %0d bad_input %0b",
                   secs, bad);
            failures++;
            return;
        end
        want = pending_results.pop_front();
        checked++;
        if (secs !== want.secs) begin
            $error("epoch_seconds: expected %0d, actual %0d", want.secs, secs);
            failures++;
        end
        if (bad !== want.bad) begin
            $error("bad_input: expected %0b, actual %0b", want.bad, bad);
            failures++;
        end
    endfunction
endclass

module tb_calendar_date_to_epoch_seconds;
    import cdte_pkg::*;

    localparam int CLK_HALF     = 4;
    localparam int RESET_CYCLES = 6;
    // The drain allows a comfortable margin on top of the pipeline latency.
    localparam int DRAIN_CYCLES = 16;
    localparam int RANDOM_ITEMS = 330;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic        i_req_type;
    logic [11:0] i_year;
    logic [3:0]  i_month;
    logic [4:0]  i_day;
    logic [2:0]  i_week_day;
    logic [4:0]  i_hour;
    logic [5:0]  i_minute;
    logic [5:0]  i_second;
    logic        o_done;
    logic [31:0] o_epoch_seconds;
    logic        o_bad_input;

    epoch_scoreboard sb;
    int unsigned     directed_count;
    int unsigned     random_count;

    calendar_date_to_epoch_seconds dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_req_type     (i_req_type),
        .i_year         (i_year),
        .i_month        (i_month),
        .i_day          (i_day),
        .i_week_day     (i_week_day),
        .i_hour         (i_hour),
        .i_minute       (i_minute),
        .i_second       (i_second),
        .o_done         (o_done),
        .o_epoch_seconds(o_epoch_seconds),
        .o_bad_input    (o_bad_input)
    );

    initial i_clk = 1'b0;
    always #(CLK_HALF) i_clk = ~i_clk;

    // Monitor: at each rising edge the result of the cycle that just ended is checked first,
    // then an input transaction accepted at this edge is recorded. A result can never belong
    // to a transaction accepted at the same edge, so the order does not matter for correctness.
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1) begin
            if (o_done === 1'b1) begin
                sb.check_result(o_epoch_seconds, o_bad_input);
            end
            if (start === 1'b1 && busy === 1'b0) begin
                sb.note_request('{i_req_type, i_year, i_month, i_day, i_week_day,
                                  i_hour, i_minute, i_second});
            end
        end
    end

    // Safety net against a hung handshake.
    initial begin
        #400us;
        $display("calendar_date_to_epoch_seconds test failed");
        $finish;
    end

    function automatic date_request_t make_request(logic mode, int unsigned y, int unsigned m,
                                                   int unsigned d, int unsigned wd,
                                                   int unsigned hh, int unsigned mm,
                                                   int unsigned ss);
        date_request_t r;
        r.req_type = mode;
        r.year     = 12'(y);
        r.month    = 4'(m);
        r.day      = 5'(d);
        r.week_day = 3'(wd);
        r.hour     = 5'(hh);
        r.minute   = 6'(mm);
        r.second   = 6'(ss);
        return r;
    endfunction

    // Most requests are valid dates with random content; about one in seven is pure noise
    // across the full width of every field, which also exercises the error path.
    function automatic date_request_t random_request();
        date_request_t r;
        r.req_type = 1'($urandom_range(1));
        if ($urandom_range(99) < 14) begin
            r.year     = 12'($urandom_range(4095));
            r.month    = 4'($urandom_range(15));
            r.day      = 5'($urandom_range(31));
            r.week_day = 3'($urandom_range(7));
            r.hour     = 5'($urandom_range(31));
            r.minute   = 6'($urandom_range(63));
            r.second   = 6'($urandom_range(63));
        end else begin
            case ($urandom_range(9))
                0:       r.year = EPOCH_YEAR;
                1:       r.year = LAST_YEAR;
                default: r.year = 12'($urandom_range(LAST_YEAR, EPOCH_YEAR));
            endcase
            r.month = 4'($urandom_range(12, 1));
            if (r.req_type == REQ_RULE && $urandom_range(3) != 0) begin
                r.day = 5'($urandom_range(6, 1));
            end else begin
                r.day = 5'($urandom_range(31, 1));
            end
            r.week_day = 3'($urandom_range(7));
            // Time fields stay in range most of the time but sometimes reach their full width.
            r.hour   = 5'(($urandom_range(9) == 0) ? $urandom_range(31) : $urandom_range(23));
            r.minute = 6'(($urandom_range(9) == 0) ? $urandom_range(63) : $urandom_range(59));
            r.second = 6'(($urandom_range(9) == 0) ? $urandom_range(63) : $urandom_range(59));
        end
        return r;
    endfunction

    // Drive one request from the falling edge on and hold it until the block takes it.
    task automatic send_request(date_request_t r);
        @(negedge i_clk);
        start      <= 1'b1;
        i_req_type <= r.req_type;
        i_year     <= r.year;
        i_month    <= r.month;
        i_day      <= r.day;
        i_week_day <= r.week_day;
        i_hour     <= r.hour;
        i_minute   <= r.minute;
        i_second   <= r.second;
        @(posedge i_clk);
        while (busy !== 1'b0) begin
            @(posedge i_clk);
        end
    endtask

    // Each idle cycle drops start for one full clock; the count is geometric so that the
    // long-run share of idle cycles matches the requested percentage.
    task automatic sender_gap(int unsigned idle_pct);
        while ($urandom_range(99) < idle_pct) begin
            @(negedge i_clk);
            start <= 1'b0;
        end
    endtask

    task automatic run_directed();
        date_request_t list[$];
        // Absolute dates at the ends of the range, leap days and month rollover.
        list.push_back(make_request(REQ_ABSOLUTE, 1970, 1, 1, 0, 0, 0, 0));
        list.push_back(make_request(REQ_ABSOLUTE, 2099, 12, 31, 0, 23, 59, 59));
        list.push_back(make_request(REQ_ABSOLUTE, 2000, 2, 29, 5, 12, 34, 56));
        list.push_back(make_request(REQ_ABSOLUTE, 2096, 2, 29, 0, 1, 2, 3));
        list.push_back(make_request(REQ_ABSOLUTE, 2023, 2, 31, 0, 6, 0, 0));
        list.push_back(make_request(REQ_ABSOLUTE, 2024, 4, 31, 0, 31, 63, 63));
        // Out of range year, month or day in either mode.
        list.push_back(make_request(REQ_ABSOLUTE, 1969, 12, 31, 0, 23, 59, 59));
        list.push_back(make_request(REQ_ABSOLUTE, 2100, 1, 1, 0, 0, 0, 0));
        list.push_back(make_request(REQ_ABSOLUTE, 4095, 15, 31, 7, 31, 63, 63));
        list.push_back(make_request(REQ_ABSOLUTE, 0, 0, 0, 0, 0, 0, 0));
        list.push_back(make_request(REQ_ABSOLUTE, 2020, 0, 10, 0, 0, 0, 0));
        list.push_back(make_request(REQ_ABSOLUTE, 2020, 13, 10, 0, 0, 0, 0));
        list.push_back(make_request(REQ_ABSOLUTE, 2020, 1, 0, 0, 0, 0, 0));
        list.push_back(make_request(REQ_RULE, 2020, 3, 0, 0, 2, 0, 0));
        list.push_back(make_request(REQ_RULE, 4095, 15, 31, 7, 31, 63, 63));
        // Weekday rules: first, nth and last occurrences, code seven acting as Sunday.
        list.push_back(make_request(REQ_RULE, 1970, 1, 1, 4, 0, 0, 0));
        list.push_back(make_request(REQ_RULE, 1970, 1, 1, 3, 0, 0, 0));
        list.push_back(make_request(REQ_RULE, 2021, 3, 2, 0, 2, 0, 0));
        list.push_back(make_request(REQ_RULE, 2021, 10, 5, 0, 1, 0, 0));
        list.push_back(make_request(REQ_RULE, 2021, 11, 1, 0, 2, 0, 0));
        list.push_back(make_request(REQ_RULE, 2099, 12, 31, 6, 23, 59, 59));
        list.push_back(make_request(REQ_RULE, 2000, 2, 4, 2, 0, 0, 0));
        list.push_back(make_request(REQ_RULE, 2024, 2, 5, 4, 0, 0, 0));
        list.push_back(make_request(REQ_RULE, 2023, 6, 3, 7, 3, 30, 0));
        list.push_back(make_request(REQ_RULE, 2015, 2, 5, 0, 0, 0, 0));
        foreach (list[i]) begin
            send_request(list[i]);
        end
        directed_count = list.size();
    endtask

    task automatic run_random(int unsigned count, int unsigned idle_pct);
        for (int unsigned n = 0; n < count; n++) begin
            sender_gap(idle_pct);
            send_request(random_request());
        end
        random_count += count;
    endtask

    initial begin
        int unsigned waited;
        sb             = new();
        directed_count = 0;
        random_count   = 0;
        i_rst_n        = 1'b0;
        start          = 1'b0;
        i_req_type     = REQ_ABSOLUTE;
        i_year         = '0;
        i_month        = '0;
        i_day          = '0;
        i_week_day     = '0;
        i_hour         = '0;
        i_minute       = '0;
        i_second       = '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        run_directed();
        // The receiver cannot hold results off, so only the sender's idle rate changes
        // between phases; the last phase streams back to back.
        run_random(RANDOM_ITEMS, 18);
        run_random(RANDOM_ITEMS, 53);
        run_random(RANDOM_ITEMS, 0);

        @(negedge i_clk);
        start <= 1'b0;
        waited = 0;
        while (sb.pending_results.size() != 0 && waited < 1000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (sb.pending_results.size() != 0) begin
            $error("%0d expected results never arrived", sb.pending_results.size());
            sb.failures += sb.pending_results.size();
        end

        $display("Converted %0d dates (%0d directed, %0d random), %0d of them rejected as bad input.",
                 sb.accepted, directed_count, random_count, sb.flagged);
        $display("Checked %0d result strobes with %0d mismatches.", sb.checked, sb.failures);
        if (sb.failures == 0) begin
            $display("calendar_date_to_epoch_seconds test passed");
        end else begin
            $display("calendar_date_to_epoch_seconds test failed");
        end
        $finish;
    end
endmodule
